@@ src/flr_pkg.sv @@
// ----------------------------------------------------------------------------
// flr_pkg
// Shared widths, constants and the line descriptor handed from the front
// part to the stepping back part of the line rasterizer.
// ----------------------------------------------------------------------------
package flr_pkg;

    localparam int COORD_W  = 6;
    localparam int LEN_W    = 7;
    localparam int COLOR_W  = 8;
    localparam int STRIDE_W = 13;
    localparam int ADDR_W   = 18;

    localparam logic [STRIDE_W-1:0] STRIDE_MAX   = 13'd4096;
    localparam logic [STRIDE_W-1:0] STRIDE_MIN   = 13'd1;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One line, already clamped and classified
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x_lo;
        logic [COORD_W-1:0] x_hi;
        logic [COORD_W-1:0] y_lo;
        logic [COORD_W-1:0] y_hi;
        logic               x_major;
        logic               major_neg;
        logic               minor_neg;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] color;
    } line_desc_t;

endpackage

@@ src/flr_front.sv @@
// ----------------------------------------------------------------------------
// flr_front
// Accepts a line request, clamps and classifies it, then works out the
// minor-axis step magnitude with a restoring divider, one quotient bit a
// cycle, and hands the finished descriptor to the queue.
// ----------------------------------------------------------------------------
module flr_front #(
    parameter int COORD_LIMIT   = 64,
    parameter int FRACTION_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [flr_pkg::COORD_W-1:0]  x_start,
    input  logic [flr_pkg::COORD_W-1:0]  y_start,
    input  logic [flr_pkg::COORD_W-1:0]  x_end,
    input  logic [flr_pkg::COORD_W-1:0]  y_end,
    input  logic [flr_pkg::COLOR_W-1:0]  color,
    output logic                         q_push,
    input  logic                         q_full,
    output flr_pkg::line_desc_t          q_desc,
    output logic [FRACTION_BITS:0]       q_mag
);
    import flr_pkg::*;

    localparam int NUM_W = LEN_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(COORD_LIMIT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    line_desc_t         desc_reg, desc_next;

    logic [COORD_W-1:0] cx0, cy0, cx1, cy1, adx, ady, dminor;
    logic               accept;
    logic [LEN_W-1:0]   shifted;
    logic [LEN_W:0]     diff;

    assign full   = (state_reg != ST_IDLE);
    assign accept = push && !full;

    // Saturate coordinates and take absolute deltas
    always_comb
    begin
        cx0 = (x_start > COORD_MAX) ? COORD_MAX : x_start;
        cy0 = (y_start > COORD_MAX) ? COORD_MAX : y_start;
        cx1 = (x_end > COORD_MAX) ? COORD_MAX : x_end;
        cy1 = (y_end > COORD_MAX) ? COORD_MAX : y_end;
        adx = (cx1 >= cx0) ? cx1 - cx0 : cx0 - cx1;
        ady = (cy1 >= cy0) ? cy1 - cy0 : cy0 - cy1;
        dminor = (adx >= ady) ? ady : adx;
    end

    // One restoring division step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = {1'b0, shifted} - {1'b0, desc_reg.len};
    end

    // Sequence accept, divide, hand over
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        desc_next  = desc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    desc_next.x0        = cx0;
                    desc_next.y0        = cy0;
                    desc_next.x_lo      = (cx0 < cx1) ? cx0 : cx1;
                    desc_next.x_hi      = (cx0 < cx1) ? cx1 : cx0;
                    desc_next.y_lo      = (cy0 < cy1) ? cy0 : cy1;
                    desc_next.y_hi      = (cy0 < cy1) ? cy1 : cy0;
                    desc_next.x_major   = (adx >= ady);
                    desc_next.major_neg = (adx >= ady) ? (cx0 > cx1) : (cy0 > cy1);
                    desc_next.minor_neg = (adx >= ady) ? (cy1 < cy0) : (cx1 < cx0);
                    desc_next.len       = LEN_W'((adx >= ady) ? adx : ady) + LEN_W'(1);
                    desc_next.color     = color;
                    quo_next   = {LEN_W'(dminor) + LEN_W'(1), {FRACTION_BITS{1'b0}}};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!diff[LEN_W])
                begin
                    rem_next = diff[COORD_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[COORD_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!q_full)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        desc_reg <= desc_next;
    end

    assign q_push = (state_reg == ST_PUSH) && !q_full;
    assign q_desc = desc_reg;
    assign q_mag  = quo_reg[FRACTION_BITS:0];

endmodule

@@ src/flr_queue.sv @@
// ----------------------------------------------------------------------------
// flr_queue
// Short descriptor queue between the front and back parts, so the divider
// can finish the next line while the back part is still drawing.
// ----------------------------------------------------------------------------
module flr_queue #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  flr_pkg::line_desc_t    wr_desc,
    input  logic [FRACTION_BITS:0] wr_mag,
    output logic                   q_full,
    input  logic                   rd_en,
    output logic                   q_empty,
    output flr_pkg::line_desc_t    rd_desc,
    output logic [FRACTION_BITS:0] rd_mag
);
    import flr_pkg::*;

    line_desc_t             desc_mem [QUEUE_DEPTH];
    logic [FRACTION_BITS:0] mag_mem  [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_desc = desc_mem[rd_ptr_reg];
    assign rd_mag  = mag_mem[rd_ptr_reg];

    // Store incoming descriptor
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_mem[wr_ptr_reg] <= wr_desc;
            mag_mem[wr_ptr_reg]  <= wr_mag;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + QCNT_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("descriptor queue occupancy above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("descriptor read from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |=> !q_empty)
        else $error("descriptor lost after write");

endmodule

@@ src/flr_back.sv @@
// ----------------------------------------------------------------------------
// flr_back
// Steps the two fixed-point accumulators one pixel a cycle while the output
// word is free or popped, clamps both coordinates to the line span, forms
// the address and holds the result word in an output register until popped.
// ----------------------------------------------------------------------------
module flr_back #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  flr_pkg::line_desc_t           q_desc,
    input  logic [FRACTION_BITS:0]        q_mag,
    input  logic [flr_pkg::STRIDE_W-1:0]  stride,
    output logic                          empty,
    input  logic                          pop,
    output logic [flr_pkg::ADDR_W-1:0]    pixel_address,
    output logic [flr_pkg::COORD_W-1:0]   pixel_x,
    output logic [flr_pkg::COORD_W-1:0]   pixel_y,
    output logic [flr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                          last_pixel
);
    import flr_pkg::*;

    localparam int ACC_W  = COORD_W + FRACTION_BITS + 2;
    localparam int PROD_W = ADDR_W + 1;
    localparam logic signed [ACC_W-1:0] ONE_FX = ACC_W'(1 << FRACTION_BITS);

    line_desc_t               desc_reg;
    logic [FRACTION_BITS:0]   mag_reg;
    logic                     active_reg;
    logic [LEN_W-1:0]         cnt_reg;
    logic signed [ACC_W-1:0]  ax_reg, ay_reg;
    logic signed [ACC_W-1:0]  sx, sy, minor_step;

    logic                     out_valid_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [COORD_W-1:0]       px_reg, py_reg;
    logic [COLOR_W-1:0]       color_reg;
    logic                     last_reg;

    logic                     adv;
    logic [COORD_W-1:0]       px, py;
    logic [PROD_W-1:0]        addr_full;

    // Floor an accumulator and hold it inside the span
    function automatic logic [COORD_W-1:0] to_pixel(
        input logic signed [ACC_W-1:0] acc,
        input logic [COORD_W-1:0]      lo,
        input logic [COORD_W-1:0]      hi
    );
        logic signed [ACC_W-1:0] lo_fx;
        logic signed [ACC_W-1:0] hi_fx;
        lo_fx = $signed(ACC_W'({lo, {FRACTION_BITS{1'b0}}}));
        hi_fx = $signed(ACC_W'({LEN_W'(hi) + LEN_W'(1), {FRACTION_BITS{1'b0}}}));
        if (acc < lo_fx)
            to_pixel = lo;
        else if (acc >= hi_fx)
            to_pixel = hi;
        else
            to_pixel = acc[FRACTION_BITS +: COORD_W];
    endfunction

    // Pick per-axis steps
    always_comb
    begin
        minor_step = desc_reg.minor_neg ? -$signed(ACC_W'(mag_reg)) : $signed(ACC_W'(mag_reg));
        if (desc_reg.x_major)
        begin
            sx = desc_reg.major_neg ? -ONE_FX : ONE_FX;
            sy = minor_step;
        end
        else
        begin
            sx = minor_step;
            sy = desc_reg.major_neg ? -ONE_FX : ONE_FX;
        end
    end

    // Current pixel and its address
    always_comb
    begin
        px = to_pixel(ax_reg, desc_reg.x_lo, desc_reg.x_hi);
        py = to_pixel(ay_reg, desc_reg.y_lo, desc_reg.y_hi);
        addr_full = PROD_W'(py) * PROD_W'(stride) + PROD_W'(px);
    end

    assign adv   = active_reg && (!out_valid_reg || pop);
    assign q_pop = !active_reg && !q_empty;

    // Load a line, then advance one pixel per free output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                active_reg <= 1'b1;
            else if (adv && cnt_reg == LEN_W'(1))
                active_reg <= 1'b0;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_desc;
            mag_reg  <= q_mag;
            cnt_reg  <= q_desc.len;
            ax_reg   <= $signed(ACC_W'({q_desc.x0, {FRACTION_BITS{1'b0}}}));
            ay_reg   <= $signed(ACC_W'({q_desc.y0, {FRACTION_BITS{1'b0}}}));
        end
        else if (adv)
        begin
            cnt_reg <= cnt_reg - LEN_W'(1);
            ax_reg  <= ax_reg + sx;
            ay_reg  <= ay_reg + sy;
        end
        if (adv)
        begin
            addr_reg  <= addr_full[ADDR_W-1:0];
            px_reg    <= px;
            py_reg    <= py;
            color_reg <= desc_reg.color;
            last_reg  <= (cnt_reg == LEN_W'(1));
        end
    end

    assign empty         = !out_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign pixel_color   = color_reg;
    assign last_pixel    = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        adv && cnt_reg == LEN_W'(1) |=> !active_reg && last_pixel)
        else $error("line did not end on its final pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> cnt_reg != '0)
        else $error("active line with no pixels left");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg &&
            $stable({addr_reg, px_reg, py_reg, color_reg, last_reg}))
        else $error("held result word overwritten");

endmodule

@@ src/fixed_point_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer
// DDA line rasterizer: one request in, one framebuffer write per pixel out.
// ----------------------------------------------------------------------------
// A request is taken when push is high and full is low. The front part
// clamps and classifies it as it is taken, works out the minor step in the
// one-bit-a-cycle divider and then hands the descriptor to a two-entry
// queue, waiting while that queue is full; full is high while it divides.
// The back part draws a line of N pixels, one pixel a cycle while pop keeps
// up, and the front part can work on the next line while it draws.
// Pixels come out from the start endpoint to the end endpoint, and
// last_pixel marks the final one. row_stride is taken on the cfg channel,
// which is always ready; 0 acts as 1 and values above 4096 act as 4096.
module fixed_point_line_rasterizer #(
    parameter int COORD_LIMIT   = 64,
    parameter int FRACTION_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [flr_pkg::STRIDE_W-1:0]  cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [flr_pkg::COORD_W-1:0]   x_start,
    input  logic [flr_pkg::COORD_W-1:0]   y_start,
    input  logic [flr_pkg::COORD_W-1:0]   x_end,
    input  logic [flr_pkg::COORD_W-1:0]   y_end,
    input  logic [flr_pkg::COLOR_W-1:0]   color,
    output logic                          empty,
    input  logic                          pop,
    output logic [flr_pkg::ADDR_W-1:0]    pixel_address,
    output logic [flr_pkg::COORD_W-1:0]   pixel_x,
    output logic [flr_pkg::COORD_W-1:0]   pixel_y,
    output logic [flr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                          last_pixel
);
    import flr_pkg::*;

    logic [STRIDE_W-1:0]    stride_reg;
    logic                   fq_push, fq_full, bq_pop, bq_empty;
    line_desc_t             fq_desc, bq_desc;
    logic [FRACTION_BITS:0] fq_mag, bq_mag;

    assign cfg_ready = 1'b1;

    // Store the stride already limited to its legal range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stride_reg <= STRIDE_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_data == '0)
                stride_reg <= STRIDE_MIN;
            else if (cfg_data > STRIDE_MAX)
                stride_reg <= STRIDE_MAX;
            else
                stride_reg <= cfg_data;
        end
    end

    flr_front #(
        .COORD_LIMIT   (COORD_LIMIT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .color   (color),
        .q_push  (fq_push),
        .q_full  (fq_full),
        .q_desc  (fq_desc),
        .q_mag   (fq_mag)
    );

    flr_queue #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_desc (fq_desc),
        .wr_mag  (fq_mag),
        .q_full  (fq_full),
        .rd_en   (bq_pop),
        .q_empty (bq_empty),
        .rd_desc (bq_desc),
        .rd_mag  (bq_mag)
    );

    flr_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (bq_empty),
        .q_pop         (bq_pop),
        .q_desc        (bq_desc),
        .q_mag         (bq_mag),
        .stride        (stride_reg),
        .empty         (empty),
        .pop           (pop),
        .pixel_address (pixel_address),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel)
    );

endmodule
